/* design/psc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and reset values of the power sequencing controller.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned CFG_W           = 16;
    localparam int unsigned CFG_IDX_W       = 8;
    localparam int unsigned STATE_CODE_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_TICKS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PUSH_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELFTEST_TICKS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_TICKS  = 8'd3;

    localparam logic [CFG_W-1:0] PUSH_TICKS_RST      = 16'd150;
    localparam logic [CFG_W-1:0] LONG_PUSH_TICKS_RST = 16'd500;
    localparam logic [CFG_W-1:0] SELFTEST_TICKS_RST  = 16'd150;
    localparam logic [CFG_W-1:0] SHUTDOWN_TICKS_RST  = 16'd3000;

    // drive line positions
    localparam int unsigned DRV_LED     = 0;
    localparam int unsigned DRV_CONV    = 1;
    localparam int unsigned DRV_BATT    = 2;
    localparam int unsigned DRV_BOUT    = 3;
    localparam int unsigned DRV_WHEEL   = 4;
    localparam int unsigned DRV_CHARGER = 5;
    localparam int unsigned DRV_W       = 6;

    // reported power state codes
    localparam logic [STATE_CODE_W-1:0] PS_INITIAL = 3'd0;
    localparam logic [STATE_CODE_W-1:0] PS_WAIT_SW = 3'd1;
    localparam logic [STATE_CODE_W-1:0] PS_SELFTEST = 3'd2;
    localparam logic [STATE_CODE_W-1:0] PS_STANDBY = 3'd3;
    localparam logic [STATE_CODE_W-1:0] PS_NORMAL  = 3'd4;
    localparam logic [STATE_CODE_W-1:0] PS_AUTO    = 3'd5;
    localparam logic [STATE_CODE_W-1:0] PS_MANUAL  = 3'd6;
    localparam logic [STATE_CODE_W-1:0] PS_HALTED  = 3'd7;

    typedef enum logic [7:0] {
        ST_INITIAL  = 8'b0000_0001,
        ST_WAIT_SW  = 8'b0000_0010,
        ST_SELFTEST = 8'b0000_0100,
        ST_STANDBY  = 8'b0000_1000,
        ST_NORMAL   = 8'b0001_0000,
        ST_AUTO     = 8'b0010_0000,
        ST_MANUAL   = 8'b0100_0000,
        ST_HALTED   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        CLS_RELEASED = 2'd0,
        CLS_PUSHED   = 2'd1,
        CLS_LONG     = 2'd2
    } t_class;

    typedef struct packed {
        logic switch_level;
        logic plugged;
        logic health_ok;
        logic converter_ok;
        logic estop_switch;
        logic host_estop;
        logic host_power_off;
        logic host_dead;
        logic host_ready;
        logic docked;
        logic chargeable;
        logic charge_end;
    } t_tick;

    // sequencer -> classifier
    typedef struct packed {
        logic step;
        logic clear;
    } t_cls_ctrl;

    function automatic logic [STATE_CODE_W-1:0] state_code(input t_state s);
        logic [STATE_CODE_W-1:0] c;
        case (s)
            ST_INITIAL:  c = PS_INITIAL;
            ST_WAIT_SW:  c = PS_WAIT_SW;
            ST_SELFTEST: c = PS_SELFTEST;
            ST_STANDBY:  c = PS_STANDBY;
            ST_NORMAL:   c = PS_NORMAL;
            ST_AUTO:     c = PS_AUTO;
            ST_MANUAL:   c = PS_MANUAL;
            ST_HALTED:   c = PS_HALTED;
            default:     c = PS_INITIAL;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/psc_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_classifier
// Push-button press classifier: hold counter restarted on each level change,
// marks pushed / long pushed while the button stays pressed.
// ----------------------------------------------------------------------------
module psc_classifier #(
    parameter int unsigned COUNT_WIDTH = psc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire psc_pkg::t_cls_ctrl        i_ctrl,
    input  wire logic                      i_level,
    input  wire logic [psc_pkg::CFG_W-1:0] i_push_ticks,
    input  wire logic [psc_pkg::CFG_W-1:0] i_long_ticks,
    output psc_pkg::t_class                o_class_next,
    output psc_pkg::t_class                o_class
);

    localparam int unsigned CMP_W =
        (COUNT_WIDTH > psc_pkg::CFG_W) ? COUNT_WIDTH : psc_pkg::CFG_W;

    logic                   r_known, n_known;
    logic                   r_prev, n_prev;
    logic                   r_run, n_run;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    psc_pkg::t_class        r_class, n_class;
    logic [CMP_W-1:0]       w_cnt_ext;

    assign w_cnt_ext = CMP_W'(n_cnt);

    always_comb begin
        n_known = r_known;
        n_prev  = r_prev;
        n_run   = r_run;
        n_cnt   = r_cnt;
        n_class = r_class;
        if (!r_known || (r_prev != i_level)) begin
            n_known = 1'b1;
            n_prev  = i_level;
            n_cnt   = '0;
            n_run   = 1'b1;
        end else begin
            if (r_run && (r_cnt != '1)) begin
                n_cnt = r_cnt + COUNT_WIDTH'(1);
            end
            // level low means pressed
            if (!i_level) begin
                if (w_cnt_ext > CMP_W'(i_long_ticks)) begin
                    n_class = psc_pkg::CLS_LONG;
                end else if ((w_cnt_ext > CMP_W'(i_push_ticks)) &&
                             (r_class == psc_pkg::CLS_RELEASED)) begin
                    n_class = psc_pkg::CLS_PUSHED;
                end
            end
        end
    end

    assign o_class_next = n_class;
    assign o_class      = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= 1'b0;
            r_prev  <= 1'b0;
            r_run   <= 1'b0;
            r_cnt   <= '0;
            r_class <= psc_pkg::CLS_RELEASED;
        end else if (i_ctrl.step) begin
            r_known <= n_known;
            r_prev  <= n_prev;
            if (i_ctrl.clear) begin
                r_run   <= 1'b0;
                r_cnt   <= '0;
                r_class <= psc_pkg::CLS_RELEASED;
            end else begin
                r_run   <= n_run;
                r_cnt   <= n_cnt;
                r_class <= n_class;
            end
        end
    end

    // a cleared step leaves the class released
    a_clear_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.step && i_ctrl.clear) |=> (r_class == psc_pkg::CLS_RELEASED) && !r_run)
        else $error("classifier not released after clear");

endmodule
`default_nettype wire

/* design/psc_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_sequencer
// Power state machine: state entries, drive lines, self-test and shutdown
// tick counters. One step per tick beat.
// ----------------------------------------------------------------------------
module psc_sequencer #(
    parameter int unsigned COUNT_WIDTH = psc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire psc_pkg::t_tick              i_tick,
    input  wire psc_pkg::t_class             i_class,
    input  wire logic [psc_pkg::CFG_W-1:0]   i_selftest_ticks,
    input  wire logic [psc_pkg::CFG_W-1:0]   i_shutdown_ticks,
    output psc_pkg::t_cls_ctrl               o_cls_ctrl,
    output psc_pkg::t_state                  o_state,
    output logic [psc_pkg::DRV_W-1:0]       o_drive,
    output logic                             o_waiting
);

    localparam int unsigned CMP_W =
        (COUNT_WIDTH > psc_pkg::CFG_W) ? COUNT_WIDTH : psc_pkg::CFG_W;

    psc_pkg::t_state             r_state, n_state;
    logic [psc_pkg::DRV_W-1:0]   r_drv, n_drv;
    logic [COUNT_WIDTH-1:0]      r_st_cnt, n_st_cnt;
    logic [COUNT_WIDTH-1:0]      r_sd_cnt, n_sd_cnt;
    logic                        r_wait, n_wait;
    logic                        r_started, n_started;
    logic                        w_clear;
    logic                        w_bad;

    // drive line changes made on entering a state
    function automatic logic [psc_pkg::DRV_W-1:0] drv_enter(
        input psc_pkg::t_state           s,
        input logic [psc_pkg::DRV_W-1:0] d
    );
        logic [psc_pkg::DRV_W-1:0] r;
        r = d;
        case (s)
            psc_pkg::ST_HALTED: begin
                r[psc_pkg::DRV_LED]  = 1'b0;
                r[psc_pkg::DRV_CONV] = 1'b0;
                r[psc_pkg::DRV_BATT] = 1'b0;
                r[psc_pkg::DRV_BOUT] = 1'b0;
            end
            psc_pkg::ST_SELFTEST: begin
                r[psc_pkg::DRV_LED]  = 1'b1;
                r[psc_pkg::DRV_BATT] = 1'b1;
                r[psc_pkg::DRV_BOUT] = 1'b0;
            end
            psc_pkg::ST_STANDBY: begin
                r[psc_pkg::DRV_CONV]    = 1'b1;
                r[psc_pkg::DRV_WHEEL]   = 1'b1;
                r[psc_pkg::DRV_BOUT]    = 1'b1;
                r[psc_pkg::DRV_CHARGER] = 1'b0;
            end
            psc_pkg::ST_NORMAL: begin
                r[psc_pkg::DRV_WHEEL]   = 1'b0;
                r[psc_pkg::DRV_BOUT]    = 1'b1;
                r[psc_pkg::DRV_CHARGER] = 1'b0;
            end
            psc_pkg::ST_AUTO: begin
                r[psc_pkg::DRV_CHARGER] = 1'b1;
            end
            psc_pkg::ST_MANUAL: begin
                r[psc_pkg::DRV_WHEEL]   = 1'b1;
                r[psc_pkg::DRV_BOUT]    = 1'b0;
                r[psc_pkg::DRV_CHARGER] = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    assign w_bad = (i_class != psc_pkg::CLS_RELEASED) || i_tick.host_power_off ||
                   !i_tick.health_ok || !i_tick.converter_ok || i_tick.estop_switch ||
                   i_tick.host_estop || i_tick.host_dead;

    always_comb begin
        n_state   = r_state;
        n_drv     = r_drv;
        n_st_cnt  = r_st_cnt;
        n_sd_cnt  = r_sd_cnt;
        n_wait    = r_wait;
        n_started = r_started;
        w_clear   = 1'b0;
        case (r_state)
            psc_pkg::ST_INITIAL: begin
                if (i_tick.plugged) begin
                    n_drv    = drv_enter(psc_pkg::ST_SELFTEST, n_drv);
                    n_st_cnt = '0;
                    n_state  = psc_pkg::ST_SELFTEST;
                end else begin
                    n_state = psc_pkg::ST_WAIT_SW;
                end
            end
            psc_pkg::ST_WAIT_SW: begin
                if (i_class != psc_pkg::CLS_RELEASED) begin
                    n_started = 1'b1;
                    w_clear   = 1'b1;
                    n_drv     = drv_enter(psc_pkg::ST_SELFTEST, n_drv);
                    n_st_cnt  = '0;
                    n_state   = psc_pkg::ST_SELFTEST;
                end
            end
            psc_pkg::ST_SELFTEST: begin
                if (r_st_cnt != '1) begin
                    n_st_cnt = r_st_cnt + COUNT_WIDTH'(1);
                end
                if ((!r_started && !i_tick.plugged) ||
                    (!i_tick.health_ok &&
                     (CMP_W'(n_st_cnt) > CMP_W'(i_selftest_ticks)))) begin
                    n_started = 1'b0;
                    n_drv     = drv_enter(psc_pkg::ST_HALTED, n_drv);
                    n_state   = psc_pkg::ST_HALTED;
                end else if (i_tick.health_ok) begin
                    n_drv   = drv_enter(psc_pkg::ST_STANDBY, n_drv);
                    n_wait  = 1'b0;
                    n_state = psc_pkg::ST_STANDBY;
                end
            end
            psc_pkg::ST_STANDBY: begin
                if (r_wait && (r_sd_cnt != '1)) begin
                    n_sd_cnt = r_sd_cnt + COUNT_WIDTH'(1);
                end
                if (!i_tick.converter_ok || (i_class == psc_pkg::CLS_LONG) ||
                    i_tick.host_dead) begin
                    n_started = 1'b0;
                    n_drv     = drv_enter(psc_pkg::ST_HALTED, n_drv);
                    n_state   = psc_pkg::ST_HALTED;
                end else if ((i_class == psc_pkg::CLS_PUSHED) ||
                             i_tick.host_power_off || !i_tick.health_ok) begin
                    if (r_wait) begin
                        if (CMP_W'(n_sd_cnt) > CMP_W'(i_shutdown_ticks)) begin
                            n_started = 1'b0;
                            n_drv     = drv_enter(psc_pkg::ST_HALTED, n_drv);
                            n_state   = psc_pkg::ST_HALTED;
                        end
                    end else begin
                        // first request: cut the load and start the shutdown wait
                        n_wait                  = 1'b1;
                        n_drv[psc_pkg::DRV_BOUT] = 1'b0;
                        n_sd_cnt                = '0;
                    end
                end else if (!i_tick.estop_switch && !i_tick.host_estop &&
                             i_tick.host_ready) begin
                    n_drv   = drv_enter(psc_pkg::ST_NORMAL, n_drv);
                    n_state = psc_pkg::ST_NORMAL;
                end
            end
            psc_pkg::ST_NORMAL: begin
                // entries stack up in order; the last one sets the state
                if (w_bad) begin
                    n_drv   = drv_enter(psc_pkg::ST_STANDBY, n_drv);
                    n_wait  = 1'b0;
                    n_state = psc_pkg::ST_STANDBY;
                end
                if (i_tick.plugged) begin
                    n_drv   = drv_enter(psc_pkg::ST_MANUAL, n_drv);
                    n_state = psc_pkg::ST_MANUAL;
                end
                if (i_tick.docked && i_tick.chargeable) begin
                    n_drv   = drv_enter(psc_pkg::ST_AUTO, n_drv);
                    n_state = psc_pkg::ST_AUTO;
                end
            end
            psc_pkg::ST_AUTO: begin
                if (w_bad) begin
                    n_drv   = drv_enter(psc_pkg::ST_STANDBY, n_drv);
                    n_wait  = 1'b0;
                    n_state = psc_pkg::ST_STANDBY;
                end
                if (i_tick.charge_end || !i_tick.docked) begin
                    n_drv   = drv_enter(psc_pkg::ST_NORMAL, n_drv);
                    n_state = psc_pkg::ST_NORMAL;
                end
            end
            psc_pkg::ST_MANUAL: begin
                if (i_class != psc_pkg::CLS_RELEASED) begin
                    w_clear = 1'b1;
                end
                if (!i_tick.plugged) begin
                    n_drv   = drv_enter(psc_pkg::ST_NORMAL, n_drv);
                    n_state = psc_pkg::ST_NORMAL;
                end
            end
            default: begin
                // halted: frozen
            end
        endcase
    end

    // classifier is frozen once halted
    assign o_cls_ctrl.step  = i_step && (r_state != psc_pkg::ST_HALTED);
    assign o_cls_ctrl.clear = w_clear;
    assign o_state          = r_state;
    assign o_drive          = r_drv;
    assign o_waiting        = r_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psc_pkg::ST_INITIAL;
            r_drv     <= '0;
            r_st_cnt  <= '0;
            r_sd_cnt  <= '0;
            r_wait    <= 1'b0;
            r_started <= 1'b0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_drv     <= n_drv;
            r_st_cnt  <= n_st_cnt;
            r_sd_cnt  <= n_sd_cnt;
            r_wait    <= n_wait;
            r_started <= n_started;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_HALTED) |=> (r_state == psc_pkg::ST_HALTED) && $stable(r_drv))
        else $error("halted state left or drive changed");

    a_halt_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_HALTED) |->
            !r_drv[psc_pkg::DRV_LED] && !r_drv[psc_pkg::DRV_CONV] &&
            !r_drv[psc_pkg::DRV_BATT] && !r_drv[psc_pkg::DRV_BOUT] && !r_started)
        else $error("power still driven while halted");

    a_manual_load_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_MANUAL) |-> !r_drv[psc_pkg::DRV_BOUT] &&
            r_drv[psc_pkg::DRV_WHEEL] && !r_drv[psc_pkg::DRV_CHARGER])
        else $error("manual charge drive lines wrong");

endmodule
`default_nettype wire

/* design/power_sequencing_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_sequencing_controller
// Power-board sequencer stepped once per tick beat: press classifier plus
// power state machine, one result beat per tick beat.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready | 12 status flags
//   out     | output    | o_out_valid / i_out_ready| state, class, drive lines
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One tick beat per cycle while the result side does not stall; a taken tick
// passes the input register, then the state registers that also hold the result.
// The state registers advance only when the result slot is free or drained,
// so an output stall holds one tick in the input register and then stalls in.
// Config writes take effect the next cycle; o_cfg_ready is always high.
// Reset (synchronous, low) loads the register defaults and the initial state.
// ----------------------------------------------------------------------------
module power_sequencing_controller #(
    parameter int unsigned COUNT_WIDTH = psc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tick input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_switch_level,
    input  wire logic                            i_plugged,
    input  wire logic                            i_health_ok,
    input  wire logic                            i_converter_ok,
    input  wire logic                            i_estop_switch,
    input  wire logic                            i_host_estop,
    input  wire logic                            i_host_power_off,
    input  wire logic                            i_host_dead,
    input  wire logic                            i_host_ready,
    input  wire logic                            i_docked,
    input  wire logic                            i_chargeable,
    input  wire logic                            i_charge_end,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [psc_pkg::STATE_CODE_W-1:0]    o_pwr_state,
    output logic [1:0]                           o_switch_class,
    output logic                                 o_switch_led,
    output logic                                 o_converter_enable,
    output logic                                 o_battery_enable,
    output logic                                 o_battery_out,
    output logic                                 o_wheel_disable,
    output logic                                 o_charger_enable,
    output logic                                 o_shutdown_pending,
    // configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [psc_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [psc_pkg::CFG_W-1:0] r_push_ticks;
    logic [psc_pkg::CFG_W-1:0] r_long_ticks;
    logic [psc_pkg::CFG_W-1:0] r_selftest_ticks;
    logic [psc_pkg::CFG_W-1:0] r_shutdown_ticks;

    logic                      r_in_valid;
    psc_pkg::t_tick            r_in;
    logic                      r_out_valid;
    logic                      w_fire;

    psc_pkg::t_cls_ctrl        w_cls_ctrl;
    psc_pkg::t_class           w_class_next;
    psc_pkg::t_class           w_class;
    psc_pkg::t_state           w_state;
    logic [psc_pkg::DRV_W-1:0] w_drive;
    logic                      w_waiting;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_ticks     <= psc_pkg::PUSH_TICKS_RST;
            r_long_ticks     <= psc_pkg::LONG_PUSH_TICKS_RST;
            r_selftest_ticks <= psc_pkg::SELFTEST_TICKS_RST;
            r_shutdown_ticks <= psc_pkg::SHUTDOWN_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psc_pkg::CFG_PUSH_TICKS:      r_push_ticks     <= i_cfg_data;
                psc_pkg::CFG_LONG_PUSH_TICKS: r_long_ticks     <= i_cfg_data;
                psc_pkg::CFG_SELFTEST_TICKS:  r_selftest_ticks <= i_cfg_data;
                psc_pkg::CFG_SHUTDOWN_TICKS:  r_shutdown_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register and result handshake
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.switch_level   <= i_switch_level;
            r_in.plugged        <= i_plugged;
            r_in.health_ok      <= i_health_ok;
            r_in.converter_ok   <= i_converter_ok;
            r_in.estop_switch   <= i_estop_switch;
            r_in.host_estop     <= i_host_estop;
            r_in.host_power_off <= i_host_power_off;
            r_in.host_dead      <= i_host_dead;
            r_in.host_ready     <= i_host_ready;
            r_in.docked         <= i_docked;
            r_in.chargeable     <= i_chargeable;
            r_in.charge_end     <= i_charge_end;
        end
    end

    psc_classifier #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classifier (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_cls_ctrl),
        .i_level      (r_in.switch_level),
        .i_push_ticks (r_push_ticks),
        .i_long_ticks (r_long_ticks),
        .o_class_next (w_class_next),
        .o_class      (w_class)
    );

    psc_sequencer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sequencer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_fire),
        .i_tick           (r_in),
        .i_class          (w_class_next),
        .i_selftest_ticks (r_selftest_ticks),
        .i_shutdown_ticks (r_shutdown_ticks),
        .o_cls_ctrl       (w_cls_ctrl),
        .o_state          (w_state),
        .o_drive          (w_drive),
        .o_waiting        (w_waiting)
    );

    // state registers hold the result until the next step
    assign o_out_valid        = r_out_valid;
    assign o_pwr_state        = psc_pkg::state_code(w_state);
    assign o_switch_class     = w_class;
    assign o_switch_led       = w_drive[psc_pkg::DRV_LED];
    assign o_converter_enable = w_drive[psc_pkg::DRV_CONV];
    assign o_battery_enable   = w_drive[psc_pkg::DRV_BATT];
    assign o_battery_out      = w_drive[psc_pkg::DRV_BOUT];
    assign o_wheel_disable    = w_drive[psc_pkg::DRV_WHEEL];
    assign o_charger_enable   = w_drive[psc_pkg::DRV_CHARGER];
    assign o_shutdown_pending = w_waiting;

    a_hold_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid && $stable(r_in))
        else $error("pending tick lost or overwritten");

    a_result_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(o_pwr_state) && $stable(w_drive) &&
            $stable(o_switch_class) && $stable(w_waiting))
        else $error("result changed while stalled");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("tick step without result");

endmodule
`default_nettype wire

/* test/power_sequencing_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_sequencing_controller_tb
// Drives tick beats into the sequencer and checks every result beat against
// a cycle-free model of the press classifier and power state machine. A short
// directed start-up walks every state except the halt, and the corner cases.
// Random phases follow, each with its own register settings. Random ticks are
// steered away from the terminal halt until the last phase, which forces a
// halt and then checks that the block stays frozen.
// ----------------------------------------------------------------------------
module power_sequencing_controller_tb;
    import psc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CNT_W       = COUNT_WIDTH_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = CFG_SHUTDOWN_TICKS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = '1;

    typedef struct packed {
        logic [STATE_CODE_W-1:0] pwr_state;
        t_class                  switch_class;
        logic                    switch_led;
        logic                    converter_enable;
        logic                    battery_enable;
        logic                    battery_out;
        logic                    wheel_disable;
        logic                    charger_enable;
        logic                    shutdown_pending;
    } t_status;

    // DUT ports
    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_in_valid       = 1'b0;
    logic                    o_in_ready;
    logic                    i_switch_level   = 1'b1;
    logic                    i_plugged        = 1'b0;
    logic                    i_health_ok      = 1'b0;
    logic                    i_converter_ok   = 1'b0;
    logic                    i_estop_switch   = 1'b0;
    logic                    i_host_estop     = 1'b0;
    logic                    i_host_power_off = 1'b0;
    logic                    i_host_dead      = 1'b0;
    logic                    i_host_ready     = 1'b0;
    logic                    i_docked         = 1'b0;
    logic                    i_chargeable     = 1'b0;
    logic                    i_charge_end     = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready      = 1'b0;
    logic [STATE_CODE_W-1:0] o_pwr_state;
    logic [1:0]              o_switch_class;
    logic                    o_switch_led;
    logic                    o_converter_enable;
    logic                    o_battery_enable;
    logic                    o_battery_out;
    logic                    o_wheel_disable;
    logic                    o_charger_enable;
    logic                    o_shutdown_pending;
    logic                    i_cfg_valid      = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index      = '0;
    logic [CFG_W-1:0]        i_cfg_data       = '0;

    // sequencer model state
    logic [STATE_CODE_W-1:0] seq_state;
    t_class                  btn_class;
    logic                    lvl_seen;
    logic                    lvl_prev;
    logic                    hold_on;
    logic [CNT_W-1:0]        hold_cnt;
    logic [CNT_W-1:0]        selftest_cnt;
    logic [CNT_W-1:0]        shutdown_cnt;
    logic                    sd_wait;
    logic                    by_switch;
    logic [DRV_W-1:0]        drv;
    logic [CFG_W-1:0]        push_lim;
    logic [CFG_W-1:0]        long_lim;
    logic [CFG_W-1:0]        selftest_lim;
    logic [CFG_W-1:0]        shutdown_lim;

    t_status expected_status[$];
    t_status observed;
    t_tick   last_tick;
    int      mismatch_count = 0;
    int      cycles         = 0;
    int      burst_left     = 0;
    int      stall_mode     = 0;
    int      stall_left     = 0;

    power_sequencing_controller u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_switch_level     (i_switch_level),
        .i_plugged          (i_plugged),
        .i_health_ok        (i_health_ok),
        .i_converter_ok     (i_converter_ok),
        .i_estop_switch     (i_estop_switch),
        .i_host_estop       (i_host_estop),
        .i_host_power_off   (i_host_power_off),
        .i_host_dead        (i_host_dead),
        .i_host_ready       (i_host_ready),
        .i_docked           (i_docked),
        .i_chargeable       (i_chargeable),
        .i_charge_end       (i_charge_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pwr_state        (o_pwr_state),
        .o_switch_class     (o_switch_class),
        .o_switch_led       (o_switch_led),
        .o_converter_enable (o_converter_enable),
        .o_battery_enable   (o_battery_enable),
        .o_battery_out      (o_battery_out),
        .o_wheel_disable    (o_wheel_disable),
        .o_charger_enable   (o_charger_enable),
        .o_shutdown_pending (o_shutdown_pending),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void reset_sequencer();
        seq_state    = PS_INITIAL;
        btn_class    = CLS_RELEASED;
        lvl_seen     = 1'b0;
        lvl_prev     = 1'b0;
        hold_on      = 1'b0;
        hold_cnt     = '0;
        selftest_cnt = '0;
        shutdown_cnt = '0;
        sd_wait      = 1'b0;
        by_switch    = 1'b0;
        drv          = '0;
        push_lim     = PUSH_TICKS_RST;
        long_lim     = LONG_PUSH_TICKS_RST;
        selftest_lim = SELFTEST_TICKS_RST;
        shutdown_lim = SHUTDOWN_TICKS_RST;
    endfunction

    function automatic void clear_press();
        hold_on   = 1'b0;
        hold_cnt  = '0;
        btn_class = CLS_RELEASED;
    endfunction

    function automatic void classify_press(input logic level);
        if (!lvl_seen || lvl_prev != level) begin
            lvl_seen = 1'b1;
            lvl_prev = level;
            hold_cnt = '0;
            hold_on  = 1'b1;
        end else begin
            if (hold_on)
                hold_cnt = sat_inc(hold_cnt);
            if (!level) begin
                if (hold_cnt > long_lim)
                    btn_class = CLS_LONG;
                else if (hold_cnt > push_lim && btn_class == CLS_RELEASED)
                    btn_class = CLS_PUSHED;
            end
        end
    endfunction

    // entry actions; several entries in one tick stack in call order
    function automatic void enter_state(input logic [STATE_CODE_W-1:0] ns);
        case (ns)
            PS_HALTED: begin
                by_switch     = 1'b0;
                drv[DRV_LED]  = 1'b0;
                drv[DRV_CONV] = 1'b0;
                drv[DRV_BATT] = 1'b0;
                drv[DRV_BOUT] = 1'b0;
            end
            PS_SELFTEST: begin
                drv[DRV_LED]  = 1'b1;
                drv[DRV_BATT] = 1'b1;
                drv[DRV_BOUT] = 1'b0;
                selftest_cnt  = '0;
            end
            PS_STANDBY: begin
                drv[DRV_CONV]    = 1'b1;
                drv[DRV_WHEEL]   = 1'b1;
                drv[DRV_BOUT]    = 1'b1;
                drv[DRV_CHARGER] = 1'b0;
                sd_wait          = 1'b0;
            end
            PS_NORMAL: begin
                drv[DRV_WHEEL]   = 1'b0;
                drv[DRV_BOUT]    = 1'b1;
                drv[DRV_CHARGER] = 1'b0;
            end
            PS_AUTO: drv[DRV_CHARGER] = 1'b1;
            PS_MANUAL: begin
                drv[DRV_WHEEL]   = 1'b1;
                drv[DRV_BOUT]    = 1'b0;
                drv[DRV_CHARGER] = 1'b0;
            end
            default: ;
        endcase
        seq_state = ns;
    endfunction

    function automatic t_status advance_sequencer(input t_tick t);
        logic    bad;
        t_class  cls;
        t_status s;
        if (seq_state != PS_HALTED) begin
            classify_press(t.switch_level);
            bad = btn_class != CLS_RELEASED || t.host_power_off || !t.health_ok ||
                  !t.converter_ok || t.estop_switch || t.host_estop || t.host_dead;
            case (seq_state)
                PS_INITIAL: enter_state(t.plugged ? PS_SELFTEST : PS_WAIT_SW);
                PS_WAIT_SW: begin
                    if (btn_class != CLS_RELEASED) begin
                        by_switch = 1'b1;
                        clear_press();
                        enter_state(PS_SELFTEST);
                    end
                end
                PS_SELFTEST: begin
                    selftest_cnt = sat_inc(selftest_cnt);
                    if (!by_switch && !t.plugged)
                        enter_state(PS_HALTED);
                    else if (t.health_ok)
                        enter_state(PS_STANDBY);
                    else if (selftest_cnt > selftest_lim)
                        enter_state(PS_HALTED);
                end
                PS_STANDBY: begin
                    cls = btn_class;
                    if (sd_wait)
                        shutdown_cnt = sat_inc(shutdown_cnt);
                    if (!t.converter_ok || cls == CLS_LONG || t.host_dead) begin
                        enter_state(PS_HALTED);
                    end else if (cls == CLS_PUSHED || t.host_power_off || !t.health_ok) begin
                        if (sd_wait) begin
                            if (shutdown_cnt > shutdown_lim)
                                enter_state(PS_HALTED);
                        end else begin
                            sd_wait       = 1'b1;
                            drv[DRV_BOUT] = 1'b0;
                            shutdown_cnt  = '0;
                        end
                    end else if (!t.estop_switch && !t.host_estop && t.host_ready) begin
                        enter_state(PS_NORMAL);
                    end
                end
                PS_NORMAL: begin
                    if (bad)
                        enter_state(PS_STANDBY);
                    if (t.plugged)
                        enter_state(PS_MANUAL);
                    if (t.docked && t.chargeable)
                        enter_state(PS_AUTO);
                end
                PS_AUTO: begin
                    if (bad)
                        enter_state(PS_STANDBY);
                    if (t.charge_end || !t.docked)
                        enter_state(PS_NORMAL);
                end
                PS_MANUAL: begin
                    if (btn_class != CLS_RELEASED)
                        clear_press();
                    if (!t.plugged)
                        enter_state(PS_NORMAL);
                end
                default: ;
            endcase
        end
        s.pwr_state        = seq_state;
        s.switch_class     = btn_class;
        s.switch_led       = drv[DRV_LED];
        s.converter_enable = drv[DRV_CONV];
        s.battery_enable   = drv[DRV_BATT];
        s.battery_out      = drv[DRV_BOUT];
        s.wheel_disable    = drv[DRV_WHEEL];
        s.charger_enable   = drv[DRV_CHARGER];
        s.shutdown_pending = sd_wait;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_tick good_tick();
        t_tick t;
        t                = '0;
        t.switch_level   = 1'b1;
        t.health_ok      = 1'b1;
        t.converter_ok   = 1'b1;
        t.host_ready     = 1'b1;
        return t;
    endfunction

    function automatic t_tick noise_tick();
        logic [$bits(t_tick)-1:0] raw;
        raw = $bits(t_tick)'($urandom_range(0, 4095));
        return raw;
    endfunction

    // Keeps random ticks out of the one-way halt: no long/pushed class where it
    // sticks, no fatal flags in standby, no shutdown wait that would time out.
    function automatic t_tick guard_tick(input t_tick t);
        int lim;
        lim = (push_lim < long_lim) ? int'(push_lim) : int'(long_lim);
        if ((seq_state == PS_STANDBY || seq_state == PS_NORMAL || seq_state == PS_AUTO) &&
            lvl_seen && !lvl_prev && hold_on && !t.switch_level &&
            int'(hold_cnt) + 1 > lim)
            t.switch_level = 1'b1;
        if (seq_state == PS_STANDBY) begin
            t.converter_ok = 1'b1;
            t.host_dead    = 1'b0;
            if (sd_wait && int'(shutdown_cnt) + 1 > int'(shutdown_lim)) begin
                t.health_ok      = 1'b1;
                t.host_power_off = 1'b0;
            end
        end
        return t;
    endfunction

    function automatic t_tick random_tick();
        t_tick t;
        t = last_tick;
        if (chance(30))
            t.switch_level = !t.switch_level;
        if (chance(8))
            t.plugged = !t.plugged;
        if (chance(12))
            t.docked = !t.docked;
        t.health_ok      = !chance(8);
        t.converter_ok   = !chance(8);
        t.estop_switch   = chance(6);
        t.host_estop     = chance(6);
        t.host_power_off = chance(6);
        t.host_dead      = chance(5);
        t.host_ready     = !chance(20);
        t.chargeable     = chance(70);
        t.charge_end     = chance(10);
        return guard_tick(t);
    endfunction

    // one tick beat; the sender runs in bursts with random gaps between them
    task automatic send_tick(input t_tick t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = chance(40) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_switch_level   <= t.switch_level;
        i_plugged        <= t.plugged;
        i_health_ok      <= t.health_ok;
        i_converter_ok   <= t.converter_ok;
        i_estop_switch   <= t.estop_switch;
        i_host_estop     <= t.host_estop;
        i_host_power_off <= t.host_power_off;
        i_host_dead      <= t.host_dead;
        i_host_ready     <= t.host_ready;
        i_docked         <= t.docked;
        i_chargeable     <= t.chargeable;
        i_charge_end     <= t.charge_end;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        last_tick = t;
        expected_status.push_back(advance_sequencer(t));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_PUSH_TICKS:      push_lim     = value;
            CFG_LONG_PUSH_TICKS: long_lim     = value;
            CFG_SELFTEST_TICKS:  selftest_lim = value;
            CFG_SHUTDOWN_TICKS:  shutdown_lim = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] push, input logic [CFG_W-1:0] lng,
                                  input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] sd);
        wait_results_drained();
        write_reg(CFG_PUSH_TICKS, push);
        write_reg(CFG_LONG_PUSH_TICKS, lng);
        write_reg(CFG_SELFTEST_TICKS, st);
        write_reg(CFG_SHUTDOWN_TICKS, sd);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [2:0] got,
                                 input logic [2:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_status(input t_status got, input t_status want);
        compare_field("pwr_state", got.pwr_state, want.pwr_state);
        compare_field("switch_class", 3'(got.switch_class), 3'(want.switch_class));
        compare_field("switch_led", 3'(got.switch_led), 3'(want.switch_led));
        compare_field("converter_enable", 3'(got.converter_enable),
                      3'(want.converter_enable));
        compare_field("battery_enable", 3'(got.battery_enable), 3'(want.battery_enable));
        compare_field("battery_out", 3'(got.battery_out), 3'(want.battery_out));
        compare_field("wheel_disable", 3'(got.wheel_disable), 3'(want.wheel_disable));
        compare_field("charger_enable", 3'(got.charger_enable), 3'(want.charger_enable));
        compare_field("shutdown_pending", 3'(got.shutdown_pending),
                      3'(want.shutdown_pending));
    endtask

    // result side: check each beat, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            observed.pwr_state        = o_pwr_state;
            observed.switch_class     = t_class'(o_switch_class);
            observed.switch_led       = o_switch_led;
            observed.converter_enable = o_converter_enable;
            observed.battery_enable   = o_battery_enable;
            observed.battery_out      = o_battery_out;
            observed.wheel_disable    = o_wheel_disable;
            observed.charger_enable   = o_charger_enable;
            observed.shutdown_pending = o_shutdown_pending;
            if (expected_status.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected, state %0d",
                                          o_pwr_state));
            else
                check_status(observed, expected_status.pop_front());
        end
        if (stall_left == 0) begin
            stall_left = $urandom_range(20, 120);
            stall_mode = $urandom_range(0, 3);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= chance(50);
            2:       i_out_ready <= (cycles % 4) != 0;
            default: i_out_ready <= chance(12);
        endcase
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_startup_sequence();
        t_tick t;
        apply_settings('0, 16'd3, '0, '0);
        write_reg(CFG_NO_REG_LO, '1);
        write_reg(CFG_NO_REG_HI, 16'h1234);
        t = good_tick();
        t.switch_level = 1'b0;
        send_tick(t);                   // first beat: level counts as a change
        send_tick(t);                   // held: pushed, self-test, classifier cleared
        send_tick(t);                   // counter stopped; health ok -> standby
        t.host_power_off = 1'b1;
        send_tick(t);                   // shutdown wait starts
        t.host_power_off = 1'b0;
        send_tick(t);                   // back to normal, pending flag left set
        t.switch_level = 1'b1;
        t.plugged = 1'b1;
        send_tick(t);                   // manual charge
        send_tick(t);
        t.switch_level = 1'b0;
        send_tick(t);
        t.plugged = 1'b0;
        send_tick(t);                   // press cleared in manual, unplug -> normal
        t.switch_level = 1'b1;
        t.docked = 1'b1;
        t.chargeable = 1'b1;
        send_tick(t);                   // auto charge
        t.estop_switch = 1'b1;
        send_tick(t);
        send_tick(t);
        t.estop_switch = 1'b0;
        t.host_estop = 1'b1;
        send_tick(t);
        t.host_estop = 1'b0;
        t.docked = 1'b0;
        t.chargeable = 1'b0;
        send_tick(t);
        t.host_dead = 1'b1;
        t.plugged = 1'b1;
        t.docked = 1'b1;
        t.chargeable = 1'b1;
        send_tick(t);                   // standby, manual and auto in one tick
        t.host_dead = 1'b0;
        t.plugged = 1'b0;
        t.health_ok = 1'b0;
        t.charge_end = 1'b1;
        send_tick(t);
        t.health_ok = 1'b1;
        t.charge_end = 1'b0;
        send_tick(t);
        t.converter_ok = 1'b0;
        t.docked = 1'b0;
        send_tick(t);
        t.converter_ok = 1'b1;
        t.host_ready = 1'b0;
        t.chargeable = 1'b0;
        send_tick(t);
    endtask

    task automatic test_sequencer_random(input logic [CFG_W-1:0] push,
                                         input logic [CFG_W-1:0] lng,
                                         input logic [CFG_W-1:0] st,
                                         input logic [CFG_W-1:0] sd, input int count);
        apply_settings(push, lng, st, sd);
        repeat (count) send_tick(random_tick());
    endtask

    // drive into the halt by one of three routes, then check the freeze
    task automatic test_halt_freeze();
        int    route;
        int    n;
        t_tick t;
        apply_settings(16'd4, 16'd10, 16'd150, 16'($urandom_range(0, 20)));
        route = $urandom_range(0, 2);
        n = 0;
        while (seq_state != PS_HALTED && n < 400) begin
            case (route)
                0: t = noise_tick();
                1: begin
                    t = good_tick();
                    t.switch_level = 1'b0;
                    t.host_ready = chance(50);
                end
                default: begin
                    t = good_tick();
                    t.host_power_off = 1'b1;
                end
            endcase
            send_tick(t);
            n++;
        end
        repeat (60) send_tick(noise_tick());
    endtask

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        reset_sequencer();
        last_tick = good_tick();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_startup_sequence();
        test_sequencer_random(16'd8, 16'd20, 16'hFFFF, 16'd12, 300);
        test_sequencer_random(16'hFFFF, 16'd0, 16'd150, 16'hFFFF, 250);
        test_sequencer_random(16'd3, 16'hFFFF, 16'd40, 16'd1, 250);
        test_halt_freeze();
        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_status.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
